@@ sv/sac_pkg.sv @@
// Shared constants and types for the sliding anagram counter.
// Used by sac_ring, sac_hist and sliding_anagram_counter; depends on nothing.
package sac_pkg;

  // Default parameter values
  localparam int MAX_PATTERN_DEF = 64;
  localparam int ALPHABET_DEF    = 26;
  localparam int COUNT_WIDTH_DEF = 32;

  // Fixed field widths of the ports
  localparam int FUNC_W   = 2;
  localparam int LETTER_W = 5;
  localparam int MATCH_W  = 32;

  // Function codes of an input item
  localparam logic [FUNC_W-1:0] FUNC_PATTERN = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_TEXT    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 2'd2;

  // Histogram update control for one executed item
  typedef struct packed {
    logic clear;     // empty both histograms
    logic pat_inc;   // count letter into the pattern histogram
    logic txt_inc;   // count letter into the window histogram
    logic drop_old;  // remove the oldest letter from the window histogram
  } hist_ctl_t;

endpackage

@@ sv/sac_ring.sv @@
// Delay line of window letters: one write port, one registered read port.
// Depends on sac_pkg for the letter width.
module sac_ring #(
  parameter int DEPTH  = sac_pkg::MAX_PATTERN_DEF,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [ADDR_W-1:0]            wr_addr,
  input  logic [sac_pkg::LETTER_W-1:0] wr_data,
  input  logic                         rd_en,
  input  logic [ADDR_W-1:0]            rd_addr,
  output logic [sac_pkg::LETTER_W-1:0] rd_data
);

  logic [sac_pkg::LETTER_W-1:0] letters [DEPTH];
  logic [sac_pkg::LETTER_W-1:0] rd_data_r;

  // Store the newest letter
  always_ff @(posedge clk) begin
    if (wr_en) begin
      letters[wr_addr] <= wr_data;
    end
  end

  // Read with forwarding of a same-cycle write to the same entry
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data_r <= wr_data;
      end else begin
        rd_data_r <= letters[rd_addr];
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ sv/sac_hist.sv @@
// Pattern and window letter histograms with the all-letter equality compare.
// Depends on sac_pkg for the control struct and letter width.
module sac_hist #(
  parameter int MAX_PATTERN = sac_pkg::MAX_PATTERN_DEF,
  parameter int ALPHABET    = sac_pkg::ALPHABET_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         upd_en,
  input  sac_pkg::hist_ctl_t           ctl,
  input  logic [sac_pkg::LETTER_W-1:0] letter,
  input  logic [sac_pkg::LETTER_W-1:0] old_letter,
  output logic                         hist_eq
);

  localparam int CNT_W = $clog2(MAX_PATTERN + 1);

  logic [CNT_W-1:0] pat_cnt_r [ALPHABET];
  logic [CNT_W-1:0] win_cnt_r [ALPHABET];
  logic [CNT_W-1:0] win_cnt_nxt [ALPHABET];
  logic [ALPHABET-1:0] lane_eq;
  logic old_ok;

  assign old_ok = (32'(old_letter) < ALPHABET);

  for (genvar i = 0; i < ALPHABET; i++) begin : g_lane
    logic inc;
    logic dec;

    // Count in the new letter, drop the oldest one
    assign inc = ctl.txt_inc && (32'(letter) == i);
    assign dec = ctl.drop_old && old_ok && (32'(old_letter) == i) &&
                 (win_cnt_r[i] != '0);

    always_comb begin
      win_cnt_nxt[i] = win_cnt_r[i];
      if (inc && !dec) begin
        win_cnt_nxt[i] = win_cnt_r[i] + 1'b1;
      end else if (dec && !inc) begin
        win_cnt_nxt[i] = win_cnt_r[i] - 1'b1;
      end
    end

    assign lane_eq[i] = (win_cnt_nxt[i] == pat_cnt_r[i]);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        pat_cnt_r[i] <= '0;
        win_cnt_r[i] <= '0;
      end else if (upd_en) begin
        if (ctl.clear) begin
          pat_cnt_r[i] <= '0;
          win_cnt_r[i] <= '0;
        end else begin
          if (ctl.pat_inc && (32'(letter) == i)) begin
            pat_cnt_r[i] <= pat_cnt_r[i] + 1'b1;
          end
          win_cnt_r[i] <= win_cnt_nxt[i];
        end
      end
    end
  end

  // Window equals pattern after this item's update
  assign hist_eq = &lane_eq;

endmodule

@@ sv/sliding_anagram_counter.sv @@
// Top level of the sliding anagram counter: input register, window control,
// result register. Instantiates sac_ring and sac_hist; depends on sac_pkg.
//
// Counts windows of a letter stream that are anagrams of a loaded pattern.
// Send pattern letters with func 0, then text letters with func 1; each text
// letter inside the alphabet yields one result (window_full, is_match and the
// saturating match count), every other item yields none. func 2 clears the
// pattern, the window and the match count. The block takes one item every
// cycle while out_ready does not stall the result: an accepted item is held
// in the input register, executed there (histogram update and the compare of
// all letter counts), and its result is shown from the output register in the
// cycle after it executes. The oldest window letter comes from a delay-line
// memory that is read as the item is taken, so the read is done before the
// item executes. No clearing pass is needed after reset. Letters at or above
// ALPHABET and pattern letters past MAX_PATTERN are ignored.
module sliding_anagram_counter #(
  parameter int MAX_PATTERN = sac_pkg::MAX_PATTERN_DEF,
  parameter int ALPHABET    = sac_pkg::ALPHABET_DEF,
  parameter int COUNT_WIDTH = sac_pkg::COUNT_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [sac_pkg::FUNC_W-1:0]   in_func,
  input  logic [sac_pkg::LETTER_W-1:0] in_letter,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_window_full,
  output logic                         out_is_match,
  output logic [sac_pkg::MATCH_W-1:0]  out_match_count
);

  localparam int CNT_W = $clog2(MAX_PATTERN + 1);
  localparam int POS_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int SUM_W = $clog2(2 * MAX_PATTERN + 1);
  localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(MAX_PATTERN);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(MAX_PATTERN - 1);

  // Input register
  logic                         s1_vld_r;
  logic [sac_pkg::FUNC_W-1:0]   s1_func_r;
  logic [sac_pkg::LETTER_W-1:0] s1_letter_r;

  // Window state
  logic [CNT_W-1:0]       plen_r, plen_nxt;
  logic [CNT_W-1:0]       fill_r, fill_nxt;
  logic [POS_W-1:0]       pos_r, pos_nxt;
  logic [COUNT_WIDTH-1:0] hits_r, hits_nxt;

  // Result register
  logic                        out_vld_r;
  logic                        out_full_r;
  logic                        out_match_r;
  logic [sac_pkg::MATCH_W-1:0] out_count_r;

  logic exec, in_xfer;
  logic letter_ok, is_clr, is_pat, is_txt, txt_store, slide;
  logic full, match, hist_eq;
  logic [sac_pkg::LETTER_W-1:0] old_letter;
  logic [SUM_W-1:0]  rd_sum;
  logic [POS_W-1:0]  rd_addr;
  sac_pkg::hist_ctl_t hctl;

  // Execute when the result register can take a result
  assign exec     = s1_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !s1_vld_r || exec;
  assign in_xfer  = in_valid && in_ready;

  // Decode the held item
  assign letter_ok = (32'(s1_letter_r) < ALPHABET);
  assign is_clr    = (s1_func_r == sac_pkg::FUNC_CLEAR);
  assign is_pat    = (s1_func_r == sac_pkg::FUNC_PATTERN) && letter_ok &&
                     (32'(plen_r) < MAX_PATTERN);
  assign is_txt    = (s1_func_r == sac_pkg::FUNC_TEXT) && letter_ok;
  assign txt_store = is_txt && (plen_r != '0);
  assign slide     = txt_store && (fill_r >= plen_r);

  // Next window state
  always_comb begin
    plen_nxt = plen_r;
    fill_nxt = fill_r;
    pos_nxt  = pos_r;
    hits_nxt = hits_r;
    if (exec) begin
      if (is_clr) begin
        plen_nxt = '0;
        fill_nxt = '0;
        pos_nxt  = '0;
        hits_nxt = '0;
      end else begin
        if (is_pat) begin
          plen_nxt = plen_r + 1'b1;
        end
        if (txt_store) begin
          if (!slide) begin
            fill_nxt = fill_r + 1'b1;
          end
          pos_nxt = (pos_r == LAST_POS) ? '0 : pos_r + 1'b1;
        end
        if (match && !(&hits_r)) begin
          hits_nxt = hits_r + 1'b1;
        end
      end
    end
  end

  assign full  = txt_store && (slide ? (fill_r == plen_r) : ((fill_r + 1'b1) == plen_r));
  assign match = full && hist_eq;

  // Oldest letter of the window as the next item will see it
  always_comb begin
    rd_sum = SUM_W'(pos_nxt) + DEPTH_S - SUM_W'(plen_nxt);
    if (rd_sum >= DEPTH_S) begin
      rd_sum = rd_sum - DEPTH_S;
    end
    rd_addr = POS_W'(rd_sum);
  end

  sac_ring #(
    .DEPTH  (MAX_PATTERN),
    .ADDR_W (POS_W)
  ) u_ring (
    .clk     (clk),
    .wr_en   (exec && txt_store),
    .wr_addr (pos_r),
    .wr_data (s1_letter_r),
    .rd_en   (in_xfer),
    .rd_addr (rd_addr),
    .rd_data (old_letter)
  );

  // Histogram update for the held item
  always_comb begin
    hctl.clear    = is_clr;
    hctl.pat_inc  = is_pat;
    hctl.txt_inc  = txt_store;
    hctl.drop_old = slide;
  end

  sac_hist #(
    .MAX_PATTERN (MAX_PATTERN),
    .ALPHABET    (ALPHABET)
  ) u_hist (
    .clk        (clk),
    .rst_n      (rst_n),
    .upd_en     (exec),
    .ctl        (hctl),
    .letter     (s1_letter_r),
    .old_letter (old_letter),
    .hist_eq    (hist_eq)
  );

  // Hold the accepted item until it executes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_ready) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_func_r   <= in_func;
      s1_letter_r <= in_letter;
    end
  end

  // Advance window state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plen_r <= '0;
      fill_r <= '0;
      pos_r  <= '0;
      hits_r <= '0;
    end else begin
      plen_r <= plen_nxt;
      fill_r <= fill_nxt;
      pos_r  <= pos_nxt;
      hits_r <= hits_nxt;
    end
  end

  // Load a result for each text letter, drop it on transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (exec && is_txt) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec && is_txt) begin
      out_full_r  <= full;
      out_match_r <= match;
      out_count_r <= sac_pkg::MATCH_W'(hits_nxt);
    end
  end

  assign out_valid       = out_vld_r;
  assign out_window_full = out_full_r;
  assign out_is_match    = out_match_r;
  assign out_match_count = out_count_r;

endmodule
